// File: hw/rtl/asa_pkg.sv
package asa_pkg;

   localparam int MaxList     = 8;
   localparam int SampleBits  = 10;
   localparam int ChanBits    = 3;
   localparam int NumChan     = 1 << ChanBits;
   localparam int PosBits     = 3;
   localparam int AccBits     = 18;
   localparam int RoundBits   = 8;
   localparam int LenBits     = 4;
   localparam int OrderBits   = MaxList * ChanBits;
   localparam int CsrIdxBits  = 2;
   localparam int CsrDataBits = OrderBits;
   localparam int DivCntBits  = $clog2(AccBits);

   localparam logic [AccBits-1:0] AccMax = {AccBits{1'b1}};

   // register indexes
   localparam logic [CsrIdxBits-1:0] CSR_AVG_SAMPLES   = 2'd0;
   localparam logic [CsrIdxBits-1:0] CSR_SCAN_LENGTH   = 2'd1;
   localparam logic [CsrIdxBits-1:0] CSR_CHANNEL_ORDER = 2'd2;

   typedef struct packed {
      logic                 start;
      logic [AccBits-1:0]   dividend;
      logic [RoundBits-1:0] divisor;
   } asa_div_cmd_type;

   typedef struct packed {
      logic               busy;
      logic               done;
      logic [AccBits-1:0] quotient;
   } asa_div_sts_type;

endpackage

// File: hw/rtl/asa_if.sv
interface asa_req_if
   import asa_pkg::*;
;
   logic                  valid;
   logic                  ready;
   logic [SampleBits-1:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

interface asa_rsp_if
   import asa_pkg::*;
;
   logic                valid;
   logic                ready;
   logic [ChanBits-1:0] channel;
   logic [AccBits-1:0]  value;
   logic                average_ready;
   logic [ChanBits-1:0] next_channel;
   logic                scan_done;

   modport source (output valid, output channel, output value, output average_ready,
                   output next_channel, output scan_done, input ready);
   modport sink   (input valid, input channel, input value, input average_ready,
                   input next_channel, input scan_done, output ready);
endinterface

// File: hw/rtl/asa_divider.sv
module asa_divider
   import asa_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  asa_div_cmd_type cmd,
   output asa_div_sts_type sts
);

   logic                  busy_ff;
   logic                  done_ff;
   logic [DivCntBits-1:0] cnt_ff;
   logic [AccBits-1:0]    quo_ff;
   logic [RoundBits-1:0]  rem_ff;
   logic [RoundBits-1:0]  dvs_ff;

   logic [RoundBits:0]    shifted;
   logic [RoundBits:0]    diff;
   logic                  fits;

   // one quotient bit per cycle, restoring
   assign shifted = {rem_ff, quo_ff[AccBits-1]};
   assign fits    = shifted >= {1'b0, dvs_ff};
   assign diff    = shifted - {1'b0, dvs_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (cmd.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= DivCntBits'(AccBits - 1);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - DivCntBits'(1);
            if (cnt_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         quo_ff <= cmd.dividend;
         rem_ff <= '0;
         dvs_ff <= cmd.divisor;
      end else if (busy_ff) begin
         quo_ff <= {quo_ff[AccBits-2:0], fits};
         rem_ff <= fits ? diff[RoundBits-1:0] : shifted[RoundBits-1:0];
      end
   end

   assign sts.busy     = busy_ff;
   assign sts.done     = done_ff;
   assign sts.quotient = quo_ff;

   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> rem_ff < dvs_ff)
      else $error("partial remainder not below divisor");

   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      cmd.start |-> !busy_ff)
      else $error("divider started while busy");

   a_done_after_last_step: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff) && $past(cnt_ff) == '0)
      else $error("divider done without finishing its steps");

endmodule

// File: hw/rtl/adc_scan_averager.sv
// adc scan averager
// Walks a list of up to eight channel numbers (csr register channel_order,
// first scan_length entries) round by round. Each word on req_bus is one
// finished conversion for the channel selected now; the block adds it into
// that channel's 18-bit accumulator (cleared on the first round, saturating)
// and on the last of avg_samples rounds replaces the sum by the sum divided
// by avg_samples. Each input word gives exactly one word on rsp_bus: the
// channel, the stored value, average_ready, the next channel to convert and
// scan_done at the end of the last round of the last entry.
// One word at a time: req_bus.ready is high only while idle. An accepted
// word passes the SUM step, on the last round the DIV step, where a shared
// restoring divider gives one quotient bit per cycle over the 18-bit sum,
// and the WRITE step, which raises rsp_bus.valid as req_bus.ready returns.
// rsp_bus is held in an output register, so a new word is accepted while
// the previous result still waits; if the receiver stalls, the next result
// waits in the sequencer until the register is free. Reset (synchronous)
// clears the list position and round count and sets avg_samples and
// scan_length to 1, channel_order to 0.
// Write registers only while idle.
module adc_scan_averager
   import asa_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [CsrIdxBits-1:0]  csr_index,
   input  logic [CsrDataBits-1:0] csr_wdata,
   asa_req_if.sink                req_bus,
   asa_rsp_if.source              rsp_bus
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SUM   = 2'd1;
   localparam logic [1:0] ST_DIV   = 2'd2;
   localparam logic [1:0] ST_WRITE = 2'd3;

   logic [1:0]            state_ff, state_in;
   logic [RoundBits-1:0]  avg_ff;
   logic [LenBits-1:0]    len_ff;
   logic [OrderBits-1:0]  order_ff;
   logic [PosBits-1:0]    pos_ff, pos_in;
   logic [RoundBits-1:0]  round_ff, round_in;

   logic [AccBits-1:0]    accum_mem [NumChan];
   logic [AccBits-1:0]    rd_ff;
   logic [SampleBits-1:0] sample_ff;
   logic [ChanBits-1:0]   chan_ff;
   logic                  first_ff;
   logic                  final_ff;
   logic [AccBits-1:0]    result_ff;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [ChanBits-1:0]   rsp_chan_ff;
   logic [AccBits-1:0]    rsp_value_ff;
   logic                  rsp_avg_ff;
   logic [ChanBits-1:0]   rsp_next_ff;
   logic                  rsp_done_ff;

   logic [RoundBits-1:0]  rounds_eff;
   logic [LenBits-1:0]    len_eff;
   logic [ChanBits-1:0]   cur_chan;
   logic [ChanBits-1:0]   next_chan;
   logic                  accept;
   logic [AccBits:0]      sum_ext;
   logic [AccBits-1:0]    sum_sat;
   logic                  out_free;
   logic                  commit;
   logic [LenBits-1:0]    pos_inc;
   logic [RoundBits:0]    round_inc;
   logic                  wrap;
   logic                  scan_end;

   asa_div_cmd_type       div_cmd;
   asa_div_sts_type       div_sts;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         avg_ff   <= RoundBits'(1);
         len_ff   <= LenBits'(1);
         order_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_AVG_SAMPLES:   avg_ff   <= csr_wdata[RoundBits-1:0];
            CSR_SCAN_LENGTH:   len_ff   <= csr_wdata[LenBits-1:0];
            CSR_CHANNEL_ORDER: order_ff <= csr_wdata[OrderBits-1:0];
            default: ;
         endcase
      end
   end

   assign rounds_eff = (avg_ff == '0) ? RoundBits'(1) : avg_ff;
   assign len_eff    = (len_ff == '0) ? LenBits'(1) :
                       (len_ff > LenBits'(MaxList)) ? LenBits'(MaxList) : len_ff;

   assign cur_chan = order_ff[pos_ff * ChanBits +: ChanBits];
   assign accept   = req_bus.valid && req_bus.ready;
   assign req_bus.ready = (state_ff == ST_IDLE);

   // accumulate with saturation
   assign sum_ext = (first_ff ? {(AccBits+1){1'b0}} : {1'b0, rd_ff})
                  + {{(AccBits+1-SampleBits){1'b0}}, sample_ff};
   assign sum_sat = sum_ext[AccBits] ? AccMax : sum_ext[AccBits-1:0];

   assign div_cmd.start    = (state_ff == ST_SUM) && final_ff;
   assign div_cmd.dividend = sum_sat;
   assign div_cmd.divisor  = rounds_eff;

   asa_divider u_divider (
      .clock (clock),
      .reset (reset),
      .cmd   (div_cmd),
      .sts   (div_sts)
   );

   // list position and round advance
   assign out_free  = !rsp_valid_ff || rsp_bus.ready;
   assign commit    = (state_ff == ST_WRITE) && out_free;
   assign pos_inc   = {1'b0, pos_ff} + LenBits'(1);
   assign wrap      = pos_inc >= len_eff;
   assign round_inc = {1'b0, round_ff} + (RoundBits+1)'(1);
   assign scan_end  = wrap && (round_inc >= {1'b0, rounds_eff});
   assign next_chan = order_ff[pos_in * ChanBits +: ChanBits];

   always_comb begin
      pos_in   = pos_ff;
      round_in = round_ff;
      if (commit) begin
         pos_in = wrap ? '0 : pos_inc[PosBits-1:0];
         if (wrap) begin
            round_in = scan_end ? '0 : round_inc[RoundBits-1:0];
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (accept) state_in = ST_SUM;
         ST_SUM:   state_in = final_ff ? ST_DIV : ST_WRITE;
         ST_DIV:   if (div_sts.done) state_in = ST_WRITE;
         ST_WRITE: if (out_free) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid_in = commit ? 1'b1 : (rsp_bus.ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pos_ff       <= '0;
         round_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         round_ff     <= round_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // accumulator store
   always_ff @(posedge clock) begin
      if (accept) begin
         rd_ff <= accum_mem[cur_chan];
      end
      if (commit) begin
         accum_mem[chan_ff] <= result_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         sample_ff <= req_bus.sample;
         chan_ff   <= cur_chan;
         first_ff  <= (round_ff == '0);
         final_ff  <= (round_ff == rounds_eff - RoundBits'(1));
      end
      if (state_ff == ST_SUM) begin
         result_ff <= sum_sat;
      end else if (state_ff == ST_DIV && div_sts.done) begin
         result_ff <= div_sts.quotient;
      end
      if (commit) begin
         rsp_chan_ff  <= chan_ff;
         rsp_value_ff <= result_ff;
         rsp_avg_ff   <= final_ff;
         rsp_next_ff  <= next_chan;
         rsp_done_ff  <= scan_end;
      end
   end

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.channel       = rsp_chan_ff;
   assign rsp_bus.value         = rsp_value_ff;
   assign rsp_bus.average_ready = rsp_avg_ff;
   assign rsp_bus.next_channel  = rsp_next_ff;
   assign rsp_bus.scan_done     = rsp_done_ff;

   a_rsp_from_write: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_WRITE)
      else $error("result word raised outside the write step");

   a_div_active: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (div_sts.busy || div_sts.done))
      else $error("waiting on an idle divider");

   a_accept_to_sum: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == ST_SUM)
      else $error("accepted word not summed next cycle");

endmodule
